// File: hdl/ray_circle_exit_time_macros.svh
// Assertion helpers used by the top-level file of this block.
`ifndef RAY_CIRCLE_EXIT_TIME_MACROS_SVH
`define RAY_CIRCLE_EXIT_TIME_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCE_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("ray_circle_exit_time: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("ray_circle_exit_time: check failed");

`endif

// File: hdl/rce_pkg.sv
package rce_pkg;

  localparam int POS_W     = 32;  // Q16.16 positions and center
  localparam int DIR_W     = 16;  // Q2.14 direction
  localparam int RADC_W    = 31;  // unsigned Q15.16 radius
  localparam int REL_W     = 33;  // pos - center
  localparam int PROD_W    = 49;  // rel * dir
  localparam int H_W       = 50;  // dot(rel, dir), Q.30
  localparam int HMAG_W    = 49;  // |h|
  localparam int HLO_W     = 25;  // low slice of |h| for the split square
  localparam int HHI_W     = HMAG_W - HLO_W;
  localparam int SQ_W      = 65;  // rel component squared
  localparam int RELSQ_W   = 66;  // dot(rel, rel)
  localparam int RR_W      = 62;  // radius squared
  localparam int K_W       = 68;  // radius^2 - dot(rel, rel)
  localparam int HSQ_W     = 98;  // h squared
  localparam int D_W       = 99;  // discriminant / 4, Q.60, signed
  localparam int RAD_W     = 98;  // radicand fed to the square root
  localparam int ROOT_W    = 49;  // floor(sqrt(D)), Q.30
  localparam int REM_W     = 51;  // square root partial remainder
  localparam int SQ_N      = ROOT_W;  // one result bit per stage
  localparam int T_W       = 52;  // candidate roots, Q.30
  localparam int FRAC_DROP = 14;  // Q.30 to Q.16
  localparam int Q_W       = T_W - FRAC_DROP;
  localparam int EXIT_W    = 32;
  localparam int FRONT_N   = 7;
  localparam int BACK_N    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic signed [T_W-1:0] RND_POS = T_W'(1 << (FRAC_DROP - 1));
  localparam logic signed [T_W-1:0] RND_NEG = T_W'((1 << (FRAC_DROP - 1)) - 1);
  localparam logic [EXIT_W-1:0] EXIT_MAX = {1'b0, {(EXIT_W-1){1'b1}}};
  localparam logic [EXIT_W-1:0] EXIT_MIN = {1'b1, {(EXIT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

  // Side information that travels with the radicand through the root.
  typedef struct packed {
    logic                  hit;
    logic signed [H_W-1:0] h;
  } rce_side_t;

endpackage

// File: hdl/ray_circle_exit_time.sv
// Ray to circle exit time. Each transaction carries a Q16.16 position and a
// Q2.14 direction; the block returns the distance along the ray to the
// configured circle (the nearer crossing when both lie ahead, otherwise the
// farther one), in Q16.16 rounded half away from zero and saturated, with
// hit low and a zero time when the ray misses. The datapath is a fully
// pipelined 59-stage chain: 7 stages form the dot products and the
// discriminant, 49 stages of the square root each resolve one root bit, and
// 3 stages select, round and saturate. A new transaction is taken every
// cycle while in_stall is low; a stall on the result side while a result
// is held freezes the whole chain. Circle registers are written through the cfg
// port, always ready, and must only change while no transaction is in flight.
`include "ray_circle_exit_time_macros.svh"

module ray_circle_exit_time (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rce_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [rce_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [rce_pkg::DIR_W-1:0]     in_dir_x,
  input  logic signed [rce_pkg::DIR_W-1:0]     in_dir_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rce_pkg::EXIT_W-1:0]    out_exit_time,
  output logic                                 out_hit,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rce_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rce_pkg::CFG_DAT_W-1:0]        cfg_data
);

  logic signed [rce_pkg::POS_W-1:0]  center_x_r, center_y_r;
  logic        [rce_pkg::RADC_W-1:0] radius_r;

  logic                              adv;
  logic                              rad_valid, root_valid;
  logic [rce_pkg::RAD_W-1:0]         rad;
  logic [rce_pkg::ROOT_W-1:0]        root;
  rce_pkg::rce_side_t                side_f, side_s;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rce_pkg::cfg_idx_t'(cfg_index))
        rce_pkg::CFG_CENTER_X: center_x_r <= cfg_data;
        rce_pkg::CFG_CENTER_Y: center_y_r <= cfg_data;
        rce_pkg::CFG_RADIUS:   radius_r   <= cfg_data[rce_pkg::RADC_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is empty or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  rce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .dir_x     (in_dir_x),
    .dir_y     (in_dir_y),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .radius    (radius_r),
    .rad_valid (rad_valid),
    .rad       (rad),
    .side      (side_f)
  );

  rce_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (rad_valid),
    .rad        (rad),
    .side_in    (side_f),
    .root_valid (root_valid),
    .root       (root),
    .side_out   (side_s)
  );

  rce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (root_valid),
    .root      (root),
    .side      (side_s),
    .out_valid (out_valid),
    .exit_time (out_exit_time),
    .hit       (out_hit)
  );

  `RCE_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !out_valid, !in_stall)
  `RCE_ASSERT_NOW(a_miss_gives_zero, clk, rst_n, out_valid && !out_hit, out_exit_time == '0)
  `RCE_ASSERT_NEXT(a_radius_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == rce_pkg::CFG_RADIUS, radius_r == $past(cfg_data[rce_pkg::RADC_W-1:0]))

endmodule

// File: hdl/rce_front.sv
module rce_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [rce_pkg::POS_W-1:0]    pos_x,
  input  logic signed [rce_pkg::POS_W-1:0]    pos_y,
  input  logic signed [rce_pkg::DIR_W-1:0]    dir_x,
  input  logic signed [rce_pkg::DIR_W-1:0]    dir_y,
  input  logic signed [rce_pkg::POS_W-1:0]    center_x,
  input  logic signed [rce_pkg::POS_W-1:0]    center_y,
  input  logic        [rce_pkg::RADC_W-1:0]   radius,
  output logic                                rad_valid,
  output logic        [rce_pkg::RAD_W-1:0]    rad,
  output rce_pkg::rce_side_t                  side
);

  logic [rce_pkg::FRONT_N-1:0] v_r;

  logic signed [rce_pkg::REL_W-1:0]   rx_r, ry_r;
  logic signed [rce_pkg::DIR_W-1:0]   dx_r, dy_r;
  logic signed [rce_pkg::PROD_W-1:0]  px_r, py_r;
  logic        [rce_pkg::SQ_W-1:0]    rxx_r, ryy_r;
  logic        [rce_pkg::RR_W-1:0]    rr_r, rr3_r;
  logic signed [rce_pkg::H_W-1:0]     h_r, h4_r, h5_r, h6_r, h7_r;
  logic        [rce_pkg::RELSQ_W-1:0] rel_r;
  logic        [rce_pkg::HMAG_W-1:0]  hm_r;
  logic signed [rce_pkg::K_W-1:0]     k_r, k5_r, k6_r;
  logic        [2*rce_pkg::HHI_W-1:0] p_hh_r;
  logic        [rce_pkg::HMAG_W-1:0]  p_hl_r;
  logic        [2*rce_pkg::HLO_W-1:0] p_ll_r;
  logic        [rce_pkg::HSQ_W-1:0]   hsq_r;
  logic        [rce_pkg::RAD_W-1:0]   rad_r;
  logic                               hit_r;

  logic signed [rce_pkg::D_W-1:0]     d_nxt;
  logic        [rce_pkg::HHI_W-1:0]   h_hi;
  logic        [rce_pkg::HLO_W-1:0]   h_lo;

  assign h_hi = hm_r[rce_pkg::HMAG_W-1:rce_pkg::HLO_W];
  assign h_lo = hm_r[rce_pkg::HLO_W-1:0];

  // The discriminant is h^2 + (radius^2 - |rel|^2) scaled to Q.60.
  assign d_nxt = $signed({1'b0, hsq_r})
               + $signed({{(rce_pkg::D_W-rce_pkg::K_W-28){k6_r[rce_pkg::K_W-1]}}, k6_r, 28'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[rce_pkg::FRONT_N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r   <= {pos_x[rce_pkg::POS_W-1], pos_x} - {center_x[rce_pkg::POS_W-1], center_x};
      ry_r   <= {pos_y[rce_pkg::POS_W-1], pos_y} - {center_y[rce_pkg::POS_W-1], center_y};
      dx_r   <= dir_x;
      dy_r   <= dir_y;

      px_r   <= rx_r * dx_r;
      py_r   <= ry_r * dy_r;
      rxx_r  <= rx_r * rx_r;
      ryy_r  <= ry_r * ry_r;
      rr_r   <= radius * radius;

      h_r    <= px_r + py_r;
      rel_r  <= rxx_r + ryy_r;
      rr3_r  <= rr_r;

      hm_r   <= h_r[rce_pkg::H_W-1] ? rce_pkg::HMAG_W'(-h_r) : h_r[rce_pkg::HMAG_W-1:0];
      k_r    <= $signed({{(rce_pkg::K_W-rce_pkg::RR_W){1'b0}}, rr3_r})
              - $signed({{(rce_pkg::K_W-rce_pkg::RELSQ_W){1'b0}}, rel_r});
      h4_r   <= h_r;

      // |h|^2 from three narrower partial products.
      p_hh_r <= h_hi * h_hi;
      p_hl_r <= h_hi * h_lo;
      p_ll_r <= h_lo * h_lo;
      h5_r   <= h4_r;
      k5_r   <= k_r;

      hsq_r  <= {p_hh_r, p_ll_r}
              + {{(rce_pkg::HSQ_W-rce_pkg::HMAG_W-rce_pkg::HLO_W-1){1'b0}},
                 p_hl_r, {(rce_pkg::HLO_W+1){1'b0}}};
      h6_r   <= h5_r;
      k6_r   <= k5_r;

      rad_r  <= d_nxt[rce_pkg::RAD_W-1:0];
      hit_r  <= !d_nxt[rce_pkg::D_W-1];
      h7_r   <= h6_r;
    end
  end

  assign rad_valid = v_r[rce_pkg::FRONT_N-1];
  assign rad       = rad_r;
  assign side.hit  = hit_r;
  assign side.h    = h7_r;

endmodule

// File: hdl/rce_sqrt.sv
module rce_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [rce_pkg::RAD_W-1:0]          rad,
  input  rce_pkg::rce_side_t                 side_in,
  output logic                               root_valid,
  output logic [rce_pkg::ROOT_W-1:0]         root,
  output rce_pkg::rce_side_t                 side_out
);

  logic                              v_r    [rce_pkg::SQ_N];
  logic [rce_pkg::REM_W-1:0]         rem_r  [rce_pkg::SQ_N];
  logic [rce_pkg::ROOT_W-1:0]        root_r [rce_pkg::SQ_N];
  logic [rce_pkg::RAD_W-1:0]         rad_r  [rce_pkg::SQ_N];
  rce_pkg::rce_side_t                side_r [rce_pkg::SQ_N];

  // Restoring digit-by-digit square root, one result bit per stage,
  // consuming two radicand bits per stage from the top down.
  for (genvar i = 0; i < rce_pkg::SQ_N; i++) begin : g_stage
    logic                        v_in;
    logic [rce_pkg::REM_W-1:0]   rem_in;
    logic [rce_pkg::ROOT_W-1:0]  root_in;
    logic [rce_pkg::RAD_W-1:0]   rad_in;
    rce_pkg::rce_side_t          side_pass;
    logic [rce_pkg::REM_W+1:0]   acc;
    logic [rce_pkg::REM_W+1:0]   trial;
    logic [rce_pkg::REM_W+1:0]   diff;
    logic                        take;

    if (i == 0) begin : g_first
      assign v_in      = in_valid;
      assign rem_in    = '0;
      assign root_in   = '0;
      assign rad_in    = rad;
      assign side_pass = side_in;
    end else begin : g_next
      assign v_in      = v_r[i-1];
      assign rem_in    = rem_r[i-1];
      assign root_in   = root_r[i-1];
      assign rad_in    = rad_r[i-1];
      assign side_pass = side_r[i-1];
    end

    assign acc   = {rem_in, rad_in[rce_pkg::RAD_W-1-2*i -: 2]};
    assign trial = {{(rce_pkg::REM_W-rce_pkg::ROOT_W){1'b0}}, root_in, 2'b01};
    assign diff  = acc - trial;
    assign take  = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= take ? diff[rce_pkg::REM_W-1:0] : acc[rce_pkg::REM_W-1:0];
        root_r[i] <= {root_in[rce_pkg::ROOT_W-2:0], take};
        rad_r[i]  <= rad_in;
        side_r[i] <= side_pass;
      end
    end
  end

  assign root_valid = v_r[rce_pkg::SQ_N-1];
  assign root       = root_r[rce_pkg::SQ_N-1];
  assign side_out   = side_r[rce_pkg::SQ_N-1];

endmodule

// File: hdl/rce_back.sv
module rce_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [rce_pkg::ROOT_W-1:0]         root,
  input  rce_pkg::rce_side_t                 side,
  output logic                               out_valid,
  output logic signed [rce_pkg::EXIT_W-1:0]  exit_time,
  output logic                               hit
);

  logic [rce_pkg::BACK_N-1:0]          v_r;
  logic signed [rce_pkg::T_W-1:0]      t1_r, t2_r;
  logic                                hit1_r, hit2_r, hit3_r;
  logic signed [rce_pkg::Q_W-1:0]      q_r;
  logic signed [rce_pkg::EXIT_W-1:0]   exit_r;

  logic signed [rce_pkg::T_W-1:0]      hx, sx, t_sel, t_rnd;
  logic                                sat;
  logic [rce_pkg::EXIT_W-1:0]          exit_nxt;

  assign hx = rce_pkg::T_W'(side.h);
  assign sx = $signed({{(rce_pkg::T_W-rce_pkg::ROOT_W){1'b0}}, root});

  // The smaller root wins only when it is strictly positive.
  assign t_sel = (t2_r > 0) ? t2_r : t1_r;
  // Round half away from zero; negatives add one less than half before the floor shift.
  assign t_rnd = t_sel + (t_sel[rce_pkg::T_W-1] ? rce_pkg::RND_NEG : rce_pkg::RND_POS);

  assign sat = (q_r[rce_pkg::Q_W-1:rce_pkg::EXIT_W-1]
                != {(rce_pkg::Q_W-rce_pkg::EXIT_W+1){q_r[rce_pkg::Q_W-1]}});

  always_comb begin
    if (!hit2_r) begin
      exit_nxt = '0;
    end else if (sat) begin
      exit_nxt = q_r[rce_pkg::Q_W-1] ? rce_pkg::EXIT_MIN : rce_pkg::EXIT_MAX;
    end else begin
      exit_nxt = q_r[rce_pkg::EXIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[rce_pkg::BACK_N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= sx - hx;
      t2_r   <= -hx - sx;
      hit1_r <= side.hit;

      q_r    <= t_rnd[rce_pkg::T_W-1:rce_pkg::FRAC_DROP];
      hit2_r <= hit1_r;

      exit_r <= exit_nxt;
      hit3_r <= hit2_r;
    end
  end

  assign out_valid = v_r[rce_pkg::BACK_N-1];
  assign exit_time = exit_r;
  assign hit       = hit3_r;

endmodule

// File: tb/tb_ray_circle_exit_time.sv
`timescale 1ns / 100ps

module tb_ray_circle_exit_time;
  import rce_pkg::*;

  localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;
  localparam logic signed [31:0] POS_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN  = 32'sh8000_0000;
  localparam logic signed [15:0] DIR_ONE  = 16'sd16384;
  localparam logic signed [15:0] DIR_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] DIR_MIN  = 16'sh8000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int PIPE_CYCLES = 59;
  localparam int RAND_PHASES = 10;
  localparam int RAND_PER_PHASE = 85;

  typedef struct {
    logic signed [31:0] exit_time;
    logic               hit;
  } ray_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [POS_W-1:0]  in_pos_x;
  logic signed [POS_W-1:0]  in_pos_y;
  logic signed [DIR_W-1:0]  in_dir_x;
  logic signed [DIR_W-1:0]  in_dir_y;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [EXIT_W-1:0] out_exit_time;
  logic                     out_hit;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;

  // Shadow copy of the circle registers.
  logic signed [31:0] circ_cx;
  logic signed [31:0] circ_cy;
  logic [30:0]        circ_r;

  ray_result_t pending_exits[$];
  ray_result_t want;
  int errors;
  int rays_checked;
  int rays_missed;
  int circles_used;
  bit tx_idle;
  bit rx_idle;
  int rx_wait;

  ray_circle_exit_time u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_exit_time (out_exit_time),
    .out_hit       (out_hit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact integer solution of t^2 + 2h*t + c = 0, rounded to Q16.16.
  function automatic ray_result_t predict_exit(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [15:0] dx,
                                               input logic signed [15:0] dy);
    ray_result_t res;
    longint rel_x, rel_y, h, h_abs, rx_abs, ry_abs, s, t, q;
    logic [127:0] w_h, w_rx, w_ry, w_r, side_pos, side_rel, disc, root, cand;
    rel_x = longint'(px) - longint'(circ_cx);
    rel_y = longint'(py) - longint'(circ_cy);
    h = rel_x * longint'(dx) + rel_y * longint'(dy);
    h_abs = (h < 0) ? -h : h;
    rx_abs = (rel_x < 0) ? -rel_x : rel_x;
    ry_abs = (rel_y < 0) ? -rel_y : rel_y;
    w_h = 128'(h_abs);
    w_rx = 128'(rx_abs);
    w_ry = 128'(ry_abs);
    w_r = 128'(circ_r);
    side_pos = w_h * w_h + ((w_r * w_r) << 28);
    side_rel = (w_rx * w_rx + w_ry * w_ry) << 28;
    res.exit_time = '0;
    res.hit = 1'b0;
    if (side_pos >= side_rel) begin
      disc = side_pos - side_rel;
      root = '0;
      for (int i = 48; i >= 0; i--) begin
        cand = root | (128'(1) << i);
        if (cand * cand <= disc) begin
          root = cand;
        end
      end
      s = longint'(root[63:0]);
      t = -h - s;
      if (t <= 0) begin
        t = -h + s;
      end
      if (t >= 0) begin
        q = (t + 8192) >>> 14;
      end else begin
        q = -((-t + 8192) >>> 14);
      end
      if (q > longint'(POS_MAX)) begin
        q = longint'(POS_MAX);
      end
      if (q < longint'(POS_MIN)) begin
        q = longint'(POS_MIN);
      end
      res.exit_time = q[31:0];
      res.hit = 1'b1;
    end
    return res;
  endfunction

  // Result side: compare each accepted transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_exits.size() == 0) begin
        $display("%0t: unexpected result: exit_time %h hit %b", $time, out_exit_time,
                 out_hit);
        errors++;
      end else begin
        want = pending_exits.pop_front();
        rays_checked++;
        if (!want.hit) begin
          rays_missed++;
        end
        if (out_exit_time !== want.exit_time) begin
          $display("%0t: exit_time mismatch: expected %h actual %h", $time,
                   want.exit_time, out_exit_time);
          errors++;
        end
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %b actual %b", $time, want.hit, out_hit);
          errors++;
        end
      end
      rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall = 1'b1;
      rx_wait--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Called and returns at a falling edge; valid stays high when the next ray follows at once.
  task automatic send_ray(input logic signed [31:0] px, input logic signed [31:0] py,
                          input logic signed [15:0] dx, input logic signed [15:0] dy);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pos_x = px;
    in_pos_y = py;
    in_dir_x = dx;
    in_dir_y = dy;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_exits.push_back(predict_exit(px, py, dx, dy));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (pending_exits.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_circle_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_results_drained();
    repeat (PIPE_CYCLES + 8) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_CENTER_X: circ_cx = data;
      CFG_CENTER_Y: circ_cy = data;
      CFG_RADIUS:   circ_r = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_circle(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [31:0] r);
    write_circle_reg(CFG_CENTER_X, cx);
    write_circle_reg(CFG_CENTER_Y, cy);
    write_circle_reg(CFG_RADIUS, r);
    circles_used++;
  endtask

  // Unit circle at the origin: inside, ahead, behind, miss, tangent, on the rim,
  // then the field extremes and very large and empty circles.
  task automatic test_directed();
    set_circle(0, 0, Q_ONE);
    send_ray(0, 0, DIR_ONE, 0);
    send_ray(-2 * Q_ONE, 0, DIR_ONE, 0);
    send_ray(3 * Q_ONE, 0, DIR_ONE, 0);
    send_ray(0, 5 * Q_ONE, DIR_ONE, 0);
    send_ray(-3 * Q_ONE, Q_ONE, DIR_ONE, 0);
    send_ray(Q_ONE, 0, DIR_ONE, 0);
    send_ray(0, 0, 0, 0);
    send_ray(0, 0, -DIR_ONE, 0);
    send_ray(0, -2 * Q_ONE, 0, DIR_ONE);
    send_ray(Q_ONE / 2, Q_ONE / 2, DIR_MAX, DIR_MIN);
    send_ray(POS_MAX, POS_MAX, DIR_ONE, DIR_ONE);
    send_ray(POS_MIN, POS_MIN, -DIR_ONE, -DIR_ONE);
    send_ray(POS_MIN, POS_MAX, DIR_MIN, DIR_MAX);
    set_circle(0, 0, 32'h7FFF_FFFF);
    send_ray(0, 0, DIR_ONE, 0);
    send_ray(POS_MIN, POS_MIN, DIR_ONE, DIR_ONE);
    send_ray(POS_MAX, POS_MIN, DIR_MIN, DIR_MAX);
    send_ray(POS_MAX, 0, DIR_MAX, 0);
    set_circle(POS_MAX, POS_MIN, 0);
    send_ray(POS_MIN, POS_MAX, DIR_ONE, 0);
    send_ray(POS_MAX, POS_MIN, 0, DIR_ONE);
    send_ray(POS_MAX, POS_MIN, DIR_MIN, DIR_MIN);
    set_circle(POS_MIN, POS_MAX, 32'h7FFF_FFFF);
    send_ray(POS_MAX, POS_MIN, DIR_MIN, DIR_MAX);
    send_ray(POS_MIN, POS_MAX, DIR_ONE, -DIR_ONE);
  endtask

  // A write to the unused index must leave the circle alone, and the top radius bit
  // is not stored.
  task automatic test_register_writes();
    set_circle(Q_ONE, -Q_ONE, 2 * Q_ONE);
    write_circle_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    send_ray(Q_ONE, -Q_ONE, DIR_ONE, 0);
    send_ray(-4 * Q_ONE, -Q_ONE, DIR_ONE, 0);
    write_circle_reg(CFG_RADIUS, 32'h8002_0000);
    send_ray(Q_ONE, -Q_ONE, 0, -DIR_ONE);
    send_ray(-4 * Q_ONE, -Q_ONE, DIR_ONE, 0);
  endtask

  function automatic logic [31:0] pick_pos_edge();
    case ($urandom_range(0, 4))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return 32'd0;
      3: return circ_cx;
      default: return circ_cy;
    endcase
  endfunction

  function automatic logic [15:0] pick_dir_edge();
    case ($urandom_range(0, 4))
      0: return DIR_ONE;
      1: return -DIR_ONE;
      2: return 16'd0;
      3: return DIR_MIN;
      default: return DIR_MAX;
    endcase
  endfunction

  // Position within a few radii of the center; wraps at the Q16.16 limits.
  function automatic logic [31:0] near_circle(input logic signed [31:0] c);
    longint span, off;
    logic [63:0] rnd;
    span = 3 * longint'(circ_r) + 65536;
    rnd = {$urandom, $urandom};
    off = longint'(rnd % (2 * span + 1)) - span;
    return 32'(longint'(c) + off);
  endfunction

  task automatic send_random_ray();
    int kind, ux, uy;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      ux = int'($urandom_range(0, 32768)) - 16384;
      uy = $rtoi($sqrt(268435456.0 - real'(ux) * real'(ux)) + 0.5);
      if ($urandom_range(0, 1)) begin
        uy = -uy;
      end
      send_ray(near_circle(circ_cx), near_circle(circ_cy), 16'(ux), 16'(uy));
    end else if (kind < 85) begin
      send_ray($urandom, $urandom, 16'($urandom), 16'($urandom));
    end else begin
      send_ray(pick_pos_edge(), pick_pos_edge(), pick_dir_edge(), pick_dir_edge());
    end
  endtask

  task automatic test_random_rays();
    logic [31:0] cx, cy, r;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          cx = $urandom_range(0, 1 << 25) - (1 << 24);
          cy = $urandom_range(0, 1 << 25) - (1 << 24);
          r = $urandom_range(1, 1 << 22);
        end
        1: begin
          cx = $urandom;
          cy = $urandom;
          r = $urandom;
        end
        2: begin
          cx = $urandom_range(0, 1 << 20) - (1 << 19);
          cy = $urandom_range(0, 1 << 20) - (1 << 19);
          r = $urandom_range(0, Q_ONE);
        end
        default: begin
          cx = $urandom;
          cy = $urandom;
          r = $urandom_range(0, 1 << 20);
        end
      endcase
      set_circle(cx, cy, r);
      tx_idle = (ph % 3) != 1;
      rx_idle = (ph % 3) != 2;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n == RAND_PER_PHASE / 2) begin
          // Let the pipeline run dry mid-phase, then refill it.
          wait_results_drained();
          tx_idle = !tx_idle;
        end
        send_random_ray();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_dir_x = '0;
    in_dir_y = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    circ_cx = '0;
    circ_cy = '0;
    circ_r = '0;
    errors = 0;
    rays_checked = 0;
    rays_missed = 0;
    circles_used = 0;
    rx_wait = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_register_writes();
    test_random_rays();

    wait_results_drained();
    repeat (PIPE_CYCLES + 8) @(negedge clk);
    $display("Checked %0d ray transactions, %0d of them misses, across %0d circles.",
             rays_checked, rays_missed, circles_used);
    $display("Covered center and radius extremes, out-of-range writes and random stalls.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
